### hw/rtl/vmu_pkg.sv
// ----------------------------------------------------------------------------
// vmu_pkg
// Shared types, codes and helpers of the four-lane fixed-point vector ALU.
// ----------------------------------------------------------------------------
package vmu_pkg;

    localparam int LANES  = 4;
    localparam int WORD_W = 32;
    localparam int WIDE_W = 66;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_SCALE     = 4'd2,
        OP_DIVIDE    = 4'd3,
        OP_DOT       = 4'd4,
        OP_CROSS     = 4'd5,
        OP_LENGTH    = 4'd6,
        OP_NORMALIZE = 4'd7,
        OP_EQUAL     = 4'd8
    } vmu_op_t;

    // execution class chosen by the front end
    typedef enum logic [4:0] {
        K_NONE   = 5'b00001,
        K_SIMPLE = 5'b00010,
        K_MUL    = 5'b00100,
        K_DIV    = 5'b01000,
        K_ROOT   = 5'b10000
    } vmu_kind_t;

    typedef logic signed [WIDE_W-1:0] vmu_wide_t;

    typedef struct packed {
        logic [3:0]                    op;
        vmu_kind_t                     kind;
        logic                          s_zero;
        logic [LANES-1:0][WORD_W-1:0]  a;
        logic [LANES-1:0][WORD_W-1:0]  b;
        logic [WORD_W-1:0]             s;
    } vmu_entry_t;

    // {overflow, saturated value}
    function automatic logic [WORD_W:0] vmu_sat(input vmu_wide_t v);
        logic [WORD_W:0] res;
        if (v > vmu_wide_t'(64'sh7FFF_FFFF))
            res = {1'b1, 32'h7FFF_FFFF};
        else if (v < -vmu_wide_t'(64'sh8000_0000))
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b0, v[WORD_W-1:0]};
        return res;
    endfunction

endpackage

### hw/rtl/vmu_front.sv
// ----------------------------------------------------------------------------
// vmu_front
// Takes commands, classifies the operation and pushes a decoded beat.
// ----------------------------------------------------------------------------
module vmu_front (
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          operation,
    input  logic [31:0]         a_x,
    input  logic [31:0]         a_y,
    input  logic [31:0]         a_z,
    input  logic [31:0]         a_w,
    input  logic [31:0]         b_x,
    input  logic [31:0]         b_y,
    input  logic [31:0]         b_z,
    input  logic [31:0]         b_w,
    input  logic [31:0]         scale_factor,
    input  logic                q_full,
    output logic                q_push,
    output vmu_pkg::vmu_entry_t q_din
);
    import vmu_pkg::*;

    always_comb
    begin
        busy   = q_full;
        q_push = start && !q_full;
        q_din.op     = operation;
        q_din.s_zero = (scale_factor == '0);
        q_din.a      = {a_w, a_z, a_y, a_x};
        q_din.b      = {b_w, b_z, b_y, b_x};
        q_din.s      = scale_factor;
        case (operation)
            OP_ADD, OP_SUB, OP_EQUAL:  q_din.kind = K_SIMPLE;
            OP_SCALE, OP_DOT, OP_CROSS: q_din.kind = K_MUL;
            OP_DIVIDE:                 q_din.kind = K_DIV;
            OP_LENGTH, OP_NORMALIZE:   q_din.kind = K_ROOT;
            default:                   q_din.kind = K_NONE;
        endcase
    end

endmodule

### hw/rtl/vmu_queue.sv
// ----------------------------------------------------------------------------
// vmu_queue
// Small register FIFO of decoded beats between front and back end.
// ----------------------------------------------------------------------------
module vmu_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vmu_pkg::vmu_entry_t din,
    input  logic                pop,
    output vmu_pkg::vmu_entry_t dout,
    output logic                full,
    output logic                empty
);
    import vmu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vmu_entry_t     mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign dout    = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= din;
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("queue pushed while full");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_reg == rd_reg))
        else $error("queue pointers inconsistent");
`endif

endmodule

### hw/rtl/vmu_back.sv
// ----------------------------------------------------------------------------
// vmu_back
// Executes decoded beats: lane arithmetic, multiplies, digit-serial square
// root and four parallel radix-2 dividers; registers each result.
// ----------------------------------------------------------------------------
module vmu_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  vmu_pkg::vmu_entry_t q_dout,
    output logic                q_pop,
    output logic                done,
    output logic [31:0]         r_x,
    output logic [31:0]         r_y,
    output logic [31:0]         r_z,
    output logic [31:0]         r_w,
    output logic [31:0]         scalar_out,
    output logic                equal_flag,
    output logic                overflow_flag,
    output logic                error_flag
);
    import vmu_pkg::*;

    localparam int DW    = WORD_W + FRACTION_BITS;   // dividend magnitude width
    localparam int RW    = WORD_W + 2;               // divider remainder width
    localparam int ROOTW = WORD_W + 1;
    localparam int REMW  = ROOTW + 3;
    localparam int RADW  = 2 * ROOTW;
    localparam int CW    = $clog2(DW);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FIN  = 5'b00100,
        S_SQRT = 5'b01000,
        S_DIV  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [3:0]                op_reg, op_next;
    vmu_kind_t                 kind_reg, kind_next;
    logic                      sz_reg, sz_next;
    logic signed [31:0]        a_reg [LANES];
    logic signed [31:0]        a_next [LANES];
    logic signed [31:0]        b_reg [LANES];
    logic signed [31:0]        b_next [LANES];
    logic signed [31:0]        s_reg, s_next;
    logic signed [63:0]        p_reg [6];
    logic signed [63:0]        p_next [6];
    logic signed [31:0]        mx [6];
    logic signed [31:0]        my [6];
    logic [RADW-1:0]           rad_reg, rad_next;
    logic [REMW-1:0]           rem_reg, rem_next;
    logic [ROOTW-1:0]          root_reg, root_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [DW-1:0]             dq_reg [LANES];
    logic [DW-1:0]             dq_next [LANES];
    logic [RW-1:0]             dr_reg [LANES];
    logic [RW-1:0]             dr_next [LANES];
    logic [LANES-1:0]          dneg_reg, dneg_next;
    logic [ROOTW-1:0]          dsor_reg, dsor_next;
    logic                      done_reg, done_next;
    logic [31:0]               r_reg [LANES];
    logic [31:0]               r_next [LANES];
    logic [31:0]               sc_reg, sc_next;
    logic                      eq_reg, eq_next;
    logic                      ovf_reg, ovf_next;
    logic                      err_reg, err_next;

    // square-root step
    logic [REMW-1:0]           rem_sh, trial, rem_step;
    logic [ROOTW-1:0]          root_step;
    logic                      root_ge;

    // divider step
    logic [RW-1:0]             d_sh [LANES];
    logic [RW-1:0]             d_rem [LANES];
    logic [DW-1:0]             d_q [LANES];

    // finish helpers
    vmu_wide_t                 fl [6];
    vmu_wide_t                 w_tmp;
    logic [WORD_W:0]           sat_v;
    logic [WIDE_W-1:0]         sq_sum;
    logic [31:0]               mag;

    always_comb
    begin
        mx = '{default: '0};
        my = '{default: '0};
        case (op_reg)
            OP_SCALE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mx[i] = a_reg[i];
                    my[i] = s_reg;
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mx[i] = a_reg[i];
                    my[i] = b_reg[i];
                end
            end
            OP_CROSS:
            begin
                mx[0] = a_reg[1]; my[0] = b_reg[2];
                mx[1] = a_reg[2]; my[1] = b_reg[1];
                mx[2] = a_reg[2]; my[2] = b_reg[0];
                mx[3] = a_reg[0]; my[3] = b_reg[2];
                mx[4] = a_reg[0]; my[4] = b_reg[1];
                mx[5] = a_reg[1]; my[5] = b_reg[0];
            end
            OP_LENGTH, OP_NORMALIZE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mx[i] = a_reg[i];
                    my[i] = a_reg[i];
                end
            end
            default:
            begin
                mx = '{default: '0};
            end
        endcase
    end

    always_comb
    begin
        rem_sh    = {rem_reg[REMW-3:0], rad_reg[RADW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        root_ge   = (rem_sh >= trial);
        rem_step  = root_ge ? rem_sh - trial : rem_sh;
        root_step = {root_reg[ROOTW-2:0], root_ge};
        for (int i = 0; i < LANES; i++)
        begin
            d_sh[i]  = {dr_reg[i][RW-2:0], dq_reg[i][DW-1]};
            d_rem[i] = (d_sh[i] >= {1'b0, dsor_reg}) ? d_sh[i] - {1'b0, dsor_reg} : d_sh[i];
            d_q[i]   = {dq_reg[i][DW-2:0], (d_sh[i] >= {1'b0, dsor_reg})};
        end
        for (int k = 0; k < 6; k++)
            fl[k] = vmu_wide_t'(p_reg[k] >>> FRACTION_BITS);
        sq_sum = {2'b00, p_reg[0]} + {2'b00, p_reg[1]} + {2'b00, p_reg[2]}
               + {2'b00, p_reg[3]};
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        kind_next  = kind_reg;
        sz_next    = sz_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        s_next     = s_reg;
        p_next     = p_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        dq_next    = dq_reg;
        dr_next    = dr_reg;
        dneg_next  = dneg_reg;
        dsor_next  = dsor_reg;
        done_next  = 1'b0;
        r_next     = r_reg;
        sc_next    = sc_reg;
        eq_next    = eq_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        q_pop      = 1'b0;
        w_tmp      = '0;
        sat_v      = '0;
        mag        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_dout.op;
                    kind_next = q_dout.kind;
                    sz_next   = q_dout.s_zero;
                    for (int i = 0; i < LANES; i++)
                    begin
                        a_next[i] = $signed(q_dout.a[i]);
                        b_next[i] = $signed(q_dout.b[i]);
                    end
                    s_next     = $signed(q_dout.s);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (kind_reg)
                    K_SIMPLE:
                    begin
                        done_next  = 1'b1;
                        r_next     = '{default: '0};
                        sc_next    = '0;
                        eq_next    = 1'b0;
                        ovf_next   = 1'b0;
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                        if (op_reg == OP_EQUAL)
                        begin
                            eq_next = 1'b1;
                            for (int i = 0; i < LANES; i++)
                                if (a_reg[i] != b_reg[i])
                                    eq_next = 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < LANES; i++)
                            begin
                                if (op_reg == OP_SUB)
                                    w_tmp = vmu_wide_t'(a_reg[i]) - vmu_wide_t'(b_reg[i]);
                                else
                                    w_tmp = vmu_wide_t'(a_reg[i]) + vmu_wide_t'(b_reg[i]);
                                sat_v     = vmu_sat(w_tmp);
                                r_next[i] = sat_v[WORD_W-1:0];
                                ovf_next  = ovf_next | sat_v[WORD_W];
                            end
                        end
                    end
                    K_MUL, K_ROOT:
                    begin
                        for (int k = 0; k < 6; k++)
                            p_next[k] = mx[k] * my[k];
                        state_next = S_FIN;
                    end
                    K_DIV:
                    begin
                        if (sz_reg)
                        begin
                            done_next  = 1'b1;
                            r_next     = '{default: '0};
                            sc_next    = '0;
                            eq_next    = 1'b0;
                            ovf_next   = 1'b0;
                            err_next   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            mag       = s_reg[31] ? 32'(-s_reg) : s_reg;
                            dsor_next = {1'b0, mag};
                            for (int i = 0; i < LANES; i++)
                            begin
                                mag          = a_reg[i][31] ? 32'(-a_reg[i]) : a_reg[i];
                                dq_next[i]   = {mag, {FRACTION_BITS{1'b0}}};
                                dr_next[i]   = '0;
                                dneg_next[i] = a_reg[i][31] ^ s_reg[31];
                            end
                            cnt_next   = CW'(DW - 1);
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        r_next     = '{default: '0};
                        sc_next    = '0;
                        eq_next    = 1'b0;
                        ovf_next   = 1'b0;
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FIN:
            begin
                if (kind_reg == K_ROOT)
                begin
                    rad_next   = RADW'(sq_sum);
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CW'(ROOTW - 1);
                    state_next = S_SQRT;
                end
                else
                begin
                    done_next  = 1'b1;
                    r_next     = '{default: '0};
                    sc_next    = '0;
                    eq_next    = 1'b0;
                    ovf_next   = 1'b0;
                    err_next   = 1'b0;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_SCALE:
                        begin
                            for (int i = 0; i < LANES; i++)
                            begin
                                sat_v     = vmu_sat(fl[i]);
                                r_next[i] = sat_v[WORD_W-1:0];
                                ovf_next  = ovf_next | sat_v[WORD_W];
                            end
                        end
                        OP_DOT:
                        begin
                            w_tmp    = fl[0] + fl[1] + fl[2] + fl[3];
                            sat_v    = vmu_sat(w_tmp);
                            sc_next  = sat_v[WORD_W-1:0];
                            ovf_next = sat_v[WORD_W];
                        end
                        OP_CROSS:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                w_tmp     = fl[2*i] - fl[2*i+1];
                                sat_v     = vmu_sat(w_tmp);
                                r_next[i] = sat_v[WORD_W-1:0];
                                ovf_next  = ovf_next | sat_v[WORD_W];
                            end
                        end
                        default:
                        begin
                            ovf_next = 1'b0;
                        end
                    endcase
                end
            end
            S_SQRT:
            begin
                rem_next  = rem_step;
                root_next = root_step;
                rad_next  = {rad_reg[RADW-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (op_reg == OP_LENGTH)
                    begin
                        sat_v      = vmu_sat(vmu_wide_t'({1'b0, root_step}));
                        done_next  = 1'b1;
                        r_next     = '{default: '0};
                        sc_next    = sat_v[WORD_W-1:0];
                        eq_next    = 1'b0;
                        ovf_next   = sat_v[WORD_W];
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (root_step == '0)
                    begin
                        done_next  = 1'b1;
                        r_next     = '{default: '0};
                        sc_next    = '0;
                        eq_next    = 1'b0;
                        ovf_next   = 1'b0;
                        err_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dsor_next = root_step;
                        for (int i = 0; i < LANES; i++)
                        begin
                            mag          = a_reg[i][31] ? 32'(-a_reg[i]) : a_reg[i];
                            dq_next[i]   = {mag, {FRACTION_BITS{1'b0}}};
                            dr_next[i]   = '0;
                            dneg_next[i] = a_reg[i][31];
                        end
                        cnt_next   = CW'(DW - 1);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                dq_next  = d_q;
                dr_next  = d_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    sc_next    = '0;
                    eq_next    = 1'b0;
                    ovf_next   = 1'b0;
                    err_next   = 1'b0;
                    state_next = S_IDLE;
                    for (int i = 0; i < LANES; i++)
                    begin
                        w_tmp     = vmu_wide_t'({{(WIDE_W - DW){1'b0}}, d_q[i]});
                        if (dneg_reg[i])
                            w_tmp = -w_tmp;
                        sat_v     = vmu_sat(w_tmp);
                        r_next[i] = sat_v[WORD_W-1:0];
                        ovf_next  = ovf_next | sat_v[WORD_W];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        kind_reg <= kind_next;
        sz_reg   <= sz_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        s_reg    <= s_next;
        p_reg    <= p_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        dq_reg   <= dq_next;
        dr_reg   <= dr_next;
        dneg_reg <= dneg_next;
        dsor_reg <= dsor_next;
        r_reg    <= r_next;
        sc_reg   <= sc_next;
        eq_reg   <= eq_next;
        ovf_reg  <= ovf_next;
        err_reg  <= err_next;
    end

    assign done          = done_reg;
    assign r_x           = r_reg[0];
    assign r_y           = r_reg[1];
    assign r_z           = r_reg[2];
    assign r_w           = r_reg[3];
    assign scalar_out    = sc_reg;
    assign equal_flag    = eq_reg;
    assign overflow_flag = ovf_reg;
    assign error_flag    = err_reg;

`ifndef SYNTH
    a_err_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && err_reg |-> (r_reg[0] == '0) && (r_reg[1] == '0)
            && (r_reg[2] == '0) && (r_reg[3] == '0) && !ovf_reg)
        else $error("error beat carries a nonzero result");
    a_eq_alone: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && eq_reg |-> !ovf_reg && !err_reg)
        else $error("equal flag with other flags");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dsor_reg != '0)
        else $error("divider running on a zero divisor");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_MUL)
        else $error("popped beat not started");
`endif

endmodule

### hw/rtl/vec4_math_unit_top.sv
// ----------------------------------------------------------------------------
// vec4_math_unit_top
// Four-lane signed fixed-point vector ALU: front end, beat queue, back end.
// ----------------------------------------------------------------------------
//   channel   handshake        payload
//   command   start / busy     operation, a_x..a_w, b_x..b_w, scale_factor
//   result    done (strobe)    r_x..r_w, scalar_out, equal/overflow/error
//
// From accept to done: add, sub, equal, unused codes end in S_MUL; scale, dot,
// cross pass S_MUL, S_FIN; divide S_MUL, S_DIV; length S_MUL, S_FIN, S_SQRT;
// normalize S_MUL, S_FIN, S_SQRT, S_DIV. The back end's serial root and divide
// loops set the throughput; busy rises only when the two-beat queue is full.
// Reset clears queue pointers, the back-end state and done.
// Results are strobed for one cycle; the receiver cannot stall.
module vec4_math_unit_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  operation,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] a_w,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] b_w,
    input  logic [31:0] scale_factor,
    output logic        done,
    output logic [31:0] r_x,
    output logic [31:0] r_y,
    output logic [31:0] r_z,
    output logic [31:0] r_w,
    output logic [31:0] scalar_out,
    output logic        equal_flag,
    output logic        overflow_flag,
    output logic        error_flag
);
    import vmu_pkg::*;

    vmu_entry_t q_din, q_dout;
    logic       q_push, q_pop, q_full, q_empty;

    vmu_front u_front (
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .a_x          (a_x),
        .a_y          (a_y),
        .a_z          (a_z),
        .a_w          (a_w),
        .b_x          (b_x),
        .b_y          (b_y),
        .b_z          (b_z),
        .b_w          (b_w),
        .scale_factor (scale_factor),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_din        (q_din)
    );

    vmu_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    vmu_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .done          (done),
        .r_x           (r_x),
        .r_y           (r_y),
        .r_z           (r_z),
        .r_w           (r_w),
        .scalar_out    (scalar_out),
        .equal_flag    (equal_flag),
        .overflow_flag (overflow_flag),
        .error_flag    (error_flag)
    );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the four-lane fixed-point vector ALU against a behavioral predictor:
// directed corner beats for every operation, then random beats with random
// sender gaps, then without; every done strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmu_pkg::*;

    localparam int FRAC = 16;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] x, y, z, w, sc;
        logic        eq, ovf, err;
    } alu_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  operation;
    logic [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor;
    logic        done;
    logic [31:0] r_x, r_y, r_z, r_w, scalar_out;
    logic        equal_flag, overflow_flag, error_flag;

    alu_result_t expected_q[$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    bit          allow_gaps;

    vec4_math_unit_top #(.FRACTION_BITS(FRAC)) i_dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp32(input longint v, inout bit ovf);
        if (v > MAXV)
        begin
            ovf = 1'b1;
            return MAXV;
        end
        if (v < MINV)
        begin
            ovf = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // product of two Q values, floored
    function automatic longint qmul(input longint p, input longint q);
        longint prod;
        prod = p * q;
        return prod >>> FRAC;
    endfunction

    function automatic logic [32:0] length_raw(input longint v [4]);
        logic [65:0]  sum;
        logic [32:0]  root;
        logic [32:0]  t;
        logic [65:0]  m;
        sum = '0;
        root = '0;
        for (int i = 0; i < 4; i++)
        begin
            m = (v[i] < 0) ? -v[i] : v[i];
            sum += m * m;
        end
        for (int bitn = 32; bitn >= 0; bitn--)
        begin
            t = root | (33'd1 << bitn);
            if ({33'd0, t} * {33'd0, t} <= sum)
                root = t;
        end
        return root;
    endfunction

    function automatic alu_result_t predict_alu(input logic [3:0] op,
            input logic [31:0] av [4], input logic [31:0] bv [4],
            input logic [31:0] sv);
        longint      a [4];
        longint      b [4];
        longint      r [4];
        longint      s;
        longint      acc;
        longint      len;
        bit          ovf;
        alu_result_t res;
        ovf = 1'b0;
        res = '0;
        s = longint'(signed'(sv));
        for (int i = 0; i < 4; i++)
        begin
            a[i] = longint'(signed'(av[i]));
            b[i] = longint'(signed'(bv[i]));
            r[i] = 0;
        end
        case (op)
            OP_ADD:
                for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] + b[i], ovf);
            OP_SUB:
                for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] - b[i], ovf);
            OP_SCALE:
                for (int i = 0; i < 4; i++) r[i] = clamp32(qmul(a[i], s), ovf);
            OP_DIVIDE:
                if (s == 0)
                    res.err = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        r[i] = clamp32((a[i] <<< FRAC) / s, ovf);
            OP_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc += qmul(a[i], b[i]);
                res.sc = 32'(clamp32(acc, ovf));
            end
            OP_CROSS:
            begin
                r[0] = clamp32(qmul(a[1], b[2]) - qmul(a[2], b[1]), ovf);
                r[1] = clamp32(qmul(a[2], b[0]) - qmul(a[0], b[2]), ovf);
                r[2] = clamp32(qmul(a[0], b[1]) - qmul(a[1], b[0]), ovf);
            end
            OP_LENGTH:
                res.sc = 32'(clamp32(longint'(length_raw(a)), ovf));
            OP_NORMALIZE:
            begin
                len = longint'(length_raw(a));
                if (len == 0)
                    res.err = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        r[i] = clamp32((a[i] <<< FRAC) / len, ovf);
            end
            OP_EQUAL:
            begin
                res.eq = 1'b1;
                for (int i = 0; i < 4; i++)
                    if (a[i] != b[i])
                        res.eq = 1'b0;
            end
            default: ;
        endcase
        res.x = 32'(r[0]);
        res.y = 32'(r[1]);
        res.z = 32'(r[2]);
        res.w = 32'(r[3]);
        res.ovf = ovf;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("MISMATCH %s at %0t: got %h want %h", what, $realtime, got, want);
        errors++;
    endtask

    // sends one beat; holds start until an edge with busy low accepts it
    task automatic send_beat(input logic [3:0] op, input logic [31:0] av [4],
            input logic [31:0] bv [4], input logic [31:0] sv);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge clk);
        end
        operation = op;
        {a_x, a_y, a_z, a_w} = {av[0], av[1], av[2], av[3]};
        {b_x, b_y, b_z, b_w} = {bv[0], bv[1], bv[2], bv[3]};
        scale_factor = sv;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_q.push_back(predict_alu(op, av, bv, sv));
        beats_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    always @(posedge clk)
    begin
        alu_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected done", 32'd1, 32'd0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (r_x !== want.x) report_mismatch("r_x", r_x, want.x);
                if (r_y !== want.y) report_mismatch("r_y", r_y, want.y);
                if (r_z !== want.z) report_mismatch("r_z", r_z, want.z);
                if (r_w !== want.w) report_mismatch("r_w", r_w, want.w);
                if (scalar_out !== want.sc)
                    report_mismatch("scalar_out", scalar_out, want.sc);
                if (equal_flag !== want.eq)
                    report_mismatch("equal_flag", equal_flag, want.eq);
                if (overflow_flag !== want.ovf)
                    report_mismatch("overflow_flag", overflow_flag, want.ovf);
                if (error_flag !== want.err)
                    report_mismatch("error_flag", error_flag, want.err);
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            4: return 32'(signed'($urandom_range(0, 32'h3FFF)) - 32'sh2000);
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        logic [31:0] av [4];
        logic [31:0] bv [4];
        logic [31:0] zv [4];
        zv = '{default: 32'h0};
        av = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000};
        bv = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_8000, 32'h0000_0001};
        for (int op = 0; op < 16; op++)
            send_beat(4'(op), av, bv, 32'h0002_0000);
        send_beat(OP_DIVIDE, av, bv, 32'h0);
        send_beat(OP_DIVIDE, av, bv, 32'hFFFF_FFFF);
        send_beat(OP_SCALE, av, bv, 32'h8000_0000);
        send_beat(OP_NORMALIZE, zv, bv, 32'h0);
        av = '{default: 32'h8000_0000};
        send_beat(OP_LENGTH, av, bv, 32'h0);
        send_beat(OP_NORMALIZE, av, bv, 32'h0);
        send_beat(OP_EQUAL, av, av, 32'h0);
        send_beat(OP_DOT, av, av, 32'h0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [31:0] av [4];
        logic [31:0] bv [4];
        logic [3:0]  op;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                av[i] = rand_word();
                bv[i] = ($urandom_range(0, 5) == 0) ? av[i] : rand_word();
            end
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            send_beat(op, av, bv, rand_word());
            // at the midpoint the sender holds off until the result queue empties
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        errors = 0;
        beats_sent = 0;
        results_seen = 0;
        allow_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor} = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        allow_gaps = 1'b1;
        test_random(600);
        allow_gaps = 1'b0;
        test_random(200);
        wait_drained();
        repeat (200) @(posedge clk);
        $display("Sent %0d beats covering all opcodes, saturation and error cases;",
                 beats_sent);
        $display("checked %0d results.", results_seen);
        if (errors == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule

### vec4_math_unit_top.f
hw/rtl/vmu_pkg.sv
hw/rtl/vmu_front.sv
hw/rtl/vmu_queue.sv
hw/rtl/vmu_back.sv
hw/rtl/vec4_math_unit_top.sv
bench/tb.sv
